/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// when cond holds, prop must hold in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("assertion failed");

// cond must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

/* src/prvu_pkg.sv */
// ----------------------------------------------------------------------------
// prvu_pkg
// Types and constants of the PageRank vertex update unit.
// ----------------------------------------------------------------------------
package prvu_pkg;

	localparam int VID_W    = 10;
	localparam int VAL_W    = 32;
	localparam int DEG_W    = 16;
	localparam int SUM_W    = 48;
	localparam int DAMP_W   = 17;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 32;

	// (sum * d) >> 16 plus (1 - d) fits 49 bits
	localparam int RANK_W   = SUM_W + 1;
	localparam int PROD_W   = 64;

	localparam int VERTEX_COUNT_DEF = 1024;

	localparam logic [DAMP_W-1:0] DAMP_ONE   = 17'd65536;
	localparam logic [DAMP_W-1:0] DAMP_RESET = 17'd55706;
	localparam logic [VAL_W-1:0]  THR_RESET  = 32'd131;
	localparam logic [VAL_W-1:0]  RANK_RESET = 32'd65536;

	localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

	typedef struct packed {
		logic [VID_W-1:0] vid;
		logic [SUM_W-1:0] sum;
		logic [DEG_W-1:0] deg;
	} job_t;

endpackage

/* src/prvu_job_fifo.sv */
// ----------------------------------------------------------------------------
// prvu_job_fifo
// Two-entry queue of per-vertex jobs between the front and the back.
// ----------------------------------------------------------------------------
module prvu_job_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  prvu_pkg::job_t wr_job,
	output logic           full,
	input  logic           rd,
	output prvu_pkg::job_t rd_job,
	output logic           empty
);
	import prvu_pkg::*;

	job_t       slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       do_wr;
	logic       do_rd;

	assign full   = (cnt_q == 2'd2);
	assign empty  = (cnt_q == 2'd0);
	assign do_wr  = wr && !full;
	assign do_rd  = rd && !empty;
	assign rd_job = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (do_wr)
				wptr_q <= !wptr_q;
			if (do_rd)
				rptr_q <= !rptr_q;
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + 2'd1;
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			slot_q[wptr_q] <= wr_job;
	end

endmodule

/* src/prvu_front.sv */
// ----------------------------------------------------------------------------
// prvu_front
// Accepts items, sums contributions and hands a job to the back on each
// last item.
// ----------------------------------------------------------------------------
module prvu_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [prvu_pkg::VID_W-1:0]   vertex_id,
	input  logic [prvu_pkg::VAL_W-1:0]   contribution,
	input  logic                         has_contribution,
	input  logic                         last_item,
	input  logic [prvu_pkg::DEG_W-1:0]   out_degree,
	input  logic                         clearing,
	input  logic                         job_full,
	output logic                         job_wr,
	output prvu_pkg::job_t               job
);
	import prvu_pkg::*;

	logic [SUM_W-1:0] sum_q;
	logic [SUM_W:0]   sum_add;
	logic [SUM_W-1:0] sum_sat;
	logic [SUM_W-1:0] sum_new;
	logic             accept;

	assign full    = clearing || job_full;
	assign accept  = push && !full;

	assign sum_add = {1'b0, sum_q} + {{(SUM_W + 1 - VAL_W){1'b0}}, contribution};
	assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
	assign sum_new = has_contribution ? sum_sat : sum_q;

	assign job_wr  = accept && last_item;
	assign job.vid = vertex_id;
	assign job.sum = sum_new;
	assign job.deg = out_degree;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			sum_q <= last_item ? '0 : sum_new;
		end
	end

endmodule

/* src/prvu_back.sv */
// ----------------------------------------------------------------------------
// prvu_back
// Per-vertex rank: damping multiply, divide by out-degree, store update and
// convergence check, with the result register toward the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prvu_back #(
	parameter int VERTEX_COUNT = prvu_pkg::VERTEX_COUNT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [prvu_pkg::DAMP_W-1:0]  damping,
	input  logic [prvu_pkg::VAL_W-1:0]   converge_threshold,
	input  prvu_pkg::job_t               job,
	input  logic                         job_empty,
	output logic                         job_rd,
	output logic                         clearing,
	output logic                         empty,
	input  logic                         pop,
	output logic [prvu_pkg::VID_W-1:0]   result_vertex,
	output logic [prvu_pkg::VAL_W-1:0]   new_rank,
	output logic                         converged
);
	import prvu_pkg::*;

	localparam int IDX_W = $clog2(VERTEX_COUNT);
	localparam int MUL_STEPS = 3;

	// index mod VERTEX_COUNT by reciprocal multiply; exact for any VID_W-bit index
	localparam int MOD_SH = 2 * VID_W;
	localparam int MOD_PW = VID_W + MOD_SH + 1;
	localparam logic [MOD_SH:0] MOD_MUL = (MOD_SH + 1)'(((64'd1 << MOD_SH)
		+ 64'(VERTEX_COUNT) - 64'd1) / 64'(VERTEX_COUNT));
	localparam bit MOD_NONE = (VERTEX_COUNT >= (1 << VID_W));
	localparam logic [VID_W-1:0] VC_LO = VID_W'(VERTEX_COUNT);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_ADD   = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_RD    = 3'd5;
	localparam logic [2:0] S_WB    = 3'd6;

	logic [2:0]        st_q;
	logic [IDX_W-1:0]  clr_q;
	logic [5:0]        cnt_q;

	logic [VID_W-1:0]  vid_q;
	logic [SUM_W-1:0]  sum_q;
	logic [DEG_W-1:0]  deg_q;
	logic [DAMP_W-1:0] d_q;
	logic [VID_W-1:0]  slot_rem_q;
	logic [PROD_W-1:0] prod_q;
	logic [RANK_W-1:0] quo_q;
	logic [DEG_W-1:0]  rem_q;

	logic              out_valid_q;
	logic [VID_W-1:0]  out_vid_q;
	logic [VAL_W-1:0]  out_rank_q;
	logic              out_conv_q;

	logic [VAL_W-1:0]  mem [VERTEX_COUNT];
	logic [VAL_W-1:0]  rdata_q;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_wa;
	logic [VAL_W-1:0]  mem_wd;
	logic [IDX_W-1:0]  slot;

	logic [MOD_PW-1:0] mod_prod;
	logic [VID_W-1:0]  mod_quo;
	logic [VID_W-1:0]  mod_rem;

	logic [15:0]       chunk;
	logic [32:0]       pp;
	logic [DEG_W:0]    trial;
	logic              trial_ge;
	logic [VAL_W-1:0]  rank_sat;
	logic [VAL_W-1:0]  diff;
	logic              out_free;
	logic              wb_go;

	assign clearing = (st_q == S_CLEAR);
	assign job_rd   = (st_q == S_IDLE) && !job_empty;
	assign slot     = IDX_W'(slot_rem_q);

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    chunk = sum_q[15:0];
			2'd1:    chunk = sum_q[31:16];
			2'd2:    chunk = sum_q[47:32];
			default: chunk = '0;
		endcase
	end
	assign pp = {17'b0, chunk} * {16'b0, d_q};

	assign mod_prod = MOD_PW'(job.vid) * MOD_PW'(MOD_MUL);
	assign mod_quo  = mod_prod[MOD_SH +: VID_W];
	assign mod_rem  = MOD_NONE ? job.vid : job.vid - mod_quo * VC_LO;

	assign trial    = {rem_q, quo_q[RANK_W-1]};
	assign trial_ge = (trial >= {1'b0, deg_q});

	assign rank_sat = (|quo_q[RANK_W-1:VAL_W]) ? {VAL_W{1'b1}} : quo_q[VAL_W-1:0];
	assign diff     = (rank_sat >= rdata_q) ? rank_sat - rdata_q : rdata_q - rank_sat;

	assign out_free = !out_valid_q || pop;
	assign wb_go    = (st_q == S_WB) && out_free;

	assign mem_we = clearing || wb_go;
	assign mem_wa = clearing ? clr_q : slot;
	assign mem_wd = clearing ? RANK_RESET : rank_sat;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rdata_q <= mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= S_CLEAR;
			clr_q <= '0;
			cnt_q <= '0;
		end else begin
			unique case (st_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == IDX_W'(VERTEX_COUNT - 1))
						st_q <= S_IDLE;
				end
				S_IDLE: begin
					cnt_q <= '0;
					if (!job_empty)
						st_q <= S_MUL;
				end
				S_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(MUL_STEPS - 1))
						st_q <= S_ADD;
				end
				S_ADD: begin
					cnt_q <= '0;
					st_q  <= (deg_q == '0) ? S_RD : S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(RANK_W - 1))
						st_q <= S_RD;
				end
				S_RD: begin
					st_q <= S_WB;
				end
				S_WB: begin
					if (out_free)
						st_q <= S_IDLE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			S_IDLE: begin
				vid_q      <= job.vid;
				sum_q      <= job.sum;
				deg_q      <= job.deg;
				d_q        <= (damping > DAMP_ONE) ? DAMP_ONE : damping;
				slot_rem_q <= mod_rem;
				prod_q     <= '0;
			end
			S_MUL: begin
				if (cnt_q < 6'(MUL_STEPS))
					prod_q <= prod_q + (PROD_W'(pp) << {cnt_q[1:0], 4'b0000});
			end
			S_ADD: begin
				quo_q <= {1'b0, prod_q[PROD_W-1:16]}
					+ RANK_W'(DAMP_ONE - d_q);
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= trial_ge ? DEG_W'(trial - {1'b0, deg_q}) : trial[DEG_W-1:0];
				quo_q <= {quo_q[RANK_W-2:0], trial_ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_go) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_go) begin
			out_vid_q  <= vid_q;
			out_rank_q <= rank_sat;
			out_conv_q <= (diff < converge_threshold);
		end
	end

	assign empty         = !out_valid_q;
	assign result_vertex = out_vid_q;
	assign new_rank      = out_rank_q;
	assign converged     = out_conv_q;

	`ASSERT_NEVER(a_clear_no_result, clk, arst_n, st_q == S_CLEAR && out_valid_q)
	`ASSERT_IMPLY(a_div_nonzero, clk, arst_n, st_q == S_DIV, deg_q != '0)
	`ASSERT_IMPLY(a_wb_after_rd, clk, arst_n, st_q == S_WB && $past(st_q) != S_WB, $past(st_q) == S_RD)
	`ASSERT_IMPLY(a_pop_idle, clk, arst_n, job_rd, st_q == S_IDLE && !job_empty)

endmodule

/* src/pagerank_vertex_update_unit.sv */
// Throughput: non-last items one per cycle while full is low; a last item occupies the back
// through the 3-step multiply, the 49-step bit-serial divider (skipped when out_degree is 0),
// the store read and the write-back, which waits for a free result register.
// A two-entry job queue lets the front keep accepting while the back works.
// Reset: asynchronous, active low; then a clear of all VERTEX_COUNT store entries holds full high.
// ----------------------------------------------------------------------------
// pagerank_vertex_update_unit
// Fixed-point PageRank vertex update with convergence flag.
// ----------------------------------------------------------------------------
module pagerank_vertex_update_unit #(
	parameter int VERTEX_COUNT = prvu_pkg::VERTEX_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	output logic                            full,
	input  logic [prvu_pkg::VID_W-1:0]      vertex_id,
	input  logic [prvu_pkg::VAL_W-1:0]      contribution,
	input  logic                            has_contribution,
	input  logic                            last_item,
	input  logic [prvu_pkg::DEG_W-1:0]      out_degree,
	output logic                            empty,
	input  logic                            pop,
	output logic [prvu_pkg::VID_W-1:0]      result_vertex,
	output logic [prvu_pkg::VAL_W-1:0]      new_rank,
	output logic                            converged,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [prvu_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [prvu_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import prvu_pkg::*;

	logic [DAMP_W-1:0] damping_q;
	logic [VAL_W-1:0]  threshold_q;
	logic              clearing;
	logic              job_full;
	logic              job_empty;
	logic              job_wr;
	logic              job_rd;
	job_t              job_in;
	job_t              job_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			damping_q   <= DAMP_RESET;
			threshold_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DAMPING)
				damping_q <= cfg_data[DAMP_W-1:0];
			else if (cfg_index == REG_THRESHOLD)
				threshold_q <= cfg_data[VAL_W-1:0];
		end
	end

	prvu_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.vertex_id        (vertex_id),
		.contribution     (contribution),
		.has_contribution (has_contribution),
		.last_item        (last_item),
		.out_degree       (out_degree),
		.clearing         (clearing),
		.job_full         (job_full),
		.job_wr           (job_wr),
		.job              (job_in)
	);

	prvu_job_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (job_wr),
		.wr_job (job_in),
		.full   (job_full),
		.rd     (job_rd),
		.rd_job (job_out),
		.empty  (job_empty)
	);

	prvu_back #(
		.VERTEX_COUNT (VERTEX_COUNT)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.damping            (damping_q),
		.converge_threshold (threshold_q),
		.job                (job_out),
		.job_empty          (job_empty),
		.job_rd             (job_rd),
		.clearing           (clearing),
		.empty              (empty),
		.pop                (pop),
		.result_vertex      (result_vertex),
		.new_rank           (new_rank),
		.converged          (converged)
	);

endmodule
